// ===== hw/rtl/pngu_pkg.sv =====
`timescale 1ns / 1ps
package pngu_pkg;

   // Default sizes
   localparam int MAX_ROW_BYTES_DEF   = 32768;
   localparam int MAX_PIXEL_BYTES_DEF = 8;
   localparam int MAX_ROWS_DEF        = 4096;

   // Left-neighbor history depth and front/back queue depth
   localparam int HIST_DEPTH  = 8;
   localparam int QUEUE_DEPTH = 4;

   // Register index codes (byte address / 4)
   localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
   localparam logic [1:0] REG_PIXEL_BYTES = 2'd1;
   localparam logic [1:0] REG_ROW_COUNT   = 2'd2;

   // Largest legal filter code
   localparam logic [7:0] FILTER_MAX = 8'd4;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } pngu_filter_type;

   // Raw configuration registers
   typedef struct packed {
      logic [15:0] row_bytes;
      logic [3:0]  pixel_bytes;
      logic [12:0] row_count;
   } pngu_cfg_type;

   // One classified beat handed from front to back
   typedef struct packed {
      logic            bad;       // bad filter code result
      logic [7:0]      data;      // raw filtered byte
      logic [15:0]     idx;       // column in the row
      pngu_filter_type filter;
      logic            last;      // last data byte of the row
      logic            use_left;  // column at or past one pixel
      logic            up_valid;  // prior-row entry has been written
      logic [2:0]      bpp_sel;   // pixel bytes minus one
   } pngu_entry_type;

   // Paeth predictor on bytes
   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic [9:0] q;
      logic [9:0] ca;
      logic [9:0] cb;
      logic [9:0] cc;
      logic [9:0] pa;
      logic [9:0] pb;
      logic [9:0] pc;
      q  = {2'b00, a} + {2'b00, b};
      ca = {2'b00, c} + {2'b00, a};
      cb = {2'b00, c} + {2'b00, b};
      cc = {2'b00, c} + {2'b00, c};
      pa = (q > ca) ? q - ca : ca - q;
      pb = (q > cb) ? q - cb : cb - q;
      pc = (q > cc) ? q - cc : cc - q;
      if (pa <= pb && pa <= pc) begin
         return a;
      end
      return (pb <= pc) ? b : c;
   endfunction

endpackage

// ===== hw/rtl/pngu_queue.sv =====
`timescale 1ns / 1ps
module pngu_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pngu_pkg::pngu_entry_type push_entry,
   input  logic                     pop,
   output logic                     head_valid,
   output pngu_pkg::pngu_entry_type head_entry,
   output logic                     full
);

   localparam int Depth = pngu_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   pngu_pkg::pngu_entry_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CntW'(Depth));
   assign head_entry = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count past depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

// ===== hw/rtl/pngu_front.sv =====
`timescale 1ns / 1ps
module pngu_front #(
   parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF,
   parameter int MAX_ROWS        = pngu_pkg::MAX_ROWS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_byte_in,
   input  pngu_pkg::pngu_cfg_type   cfg,
   input  logic                     q_full,
   output logic                     q_push,
   output pngu_pkg::pngu_entry_type q_entry
);

   localparam int ColW = $clog2(MAX_ROW_BYTES + 1);
   localparam int RowW = $clog2(MAX_ROWS + 1);
   localparam logic [16:0] MaxRb   = 17'(MAX_ROW_BYTES);
   localparam logic [16:0] MaxRows = 17'(MAX_ROWS);
   localparam logic [3:0]  MaxPb   = 4'(MAX_PIXEL_BYTES);

   logic                      expect_filter_ff;
   logic                      expect_filter_in;
   pngu_pkg::pngu_filter_type filter_ff;
   pngu_pkg::pngu_filter_type filter_in;
   logic [ColW-1:0]           col_ff;
   logic [ColW-1:0]           col_in;
   logic [ColW-1:0]           hwm_ff;
   logic [ColW-1:0]           hwm_in;
   logic [RowW-1:0]           rows_done_ff;
   logic [RowW-1:0]           rows_done_in;
   logic                      halted_ff;
   logic                      halted_in;

   logic [16:0] rb_ext;
   logic [16:0] rb_eff;
   logic [16:0] rc_ext;
   logic [16:0] rc_eff;
   logic [3:0]  pb_eff;
   logic [16:0] col_next;
   logic        accept;
   logic        active;
   logic        last;
   logic        up_valid;

   // Clamp registers to legal ranges
   always_comb begin
      rb_ext = {1'b0, cfg.row_bytes};
      if (rb_ext == '0) begin
         rb_eff = 17'd1;
      end else if (rb_ext > MaxRb) begin
         rb_eff = MaxRb;
      end else begin
         rb_eff = rb_ext;
      end
      rc_ext = 17'(cfg.row_count);
      rc_eff = (rc_ext > MaxRows) ? MaxRows : rc_ext;
      if (cfg.pixel_bytes == '0) begin
         pb_eff = 4'd1;
      end else if (cfg.pixel_bytes > MaxPb) begin
         pb_eff = MaxPb;
      end else begin
         pb_eff = cfg.pixel_bytes;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign active    = accept && !halted_ff && (17'(rows_done_ff) < rc_eff);
   assign col_next  = 17'(col_ff) + 17'd1;
   assign last      = (col_next >= rb_eff);
   assign up_valid  = (col_ff < hwm_ff);

   // Classify beat, track row position
   always_comb begin
      expect_filter_in = expect_filter_ff;
      filter_in        = filter_ff;
      col_in           = col_ff;
      hwm_in           = hwm_ff;
      rows_done_in     = rows_done_ff;
      halted_in        = halted_ff;
      q_push           = 1'b0;
      q_entry          = '0;
      q_entry.data     = req_byte_in;
      q_entry.idx      = 16'(col_ff);
      q_entry.filter   = filter_ff;
      q_entry.last     = last;
      q_entry.use_left = (17'(col_ff) >= 17'(pb_eff));
      q_entry.up_valid = up_valid;
      q_entry.bpp_sel  = 3'(pb_eff - 4'd1);
      if (active && expect_filter_ff) begin
         if (req_byte_in > pngu_pkg::FILTER_MAX) begin
            halted_in   = 1'b1;
            q_push      = 1'b1;
            q_entry     = '0;
            q_entry.bad = 1'b1;
         end else begin
            filter_in        = pngu_pkg::pngu_filter_type'(req_byte_in[2:0]);
            expect_filter_in = 1'b0;
         end
      end else if (active) begin
         q_push = 1'b1;
         if (!up_valid) begin
            hwm_in = col_next[ColW-1:0];
         end
         if (last) begin
            col_in           = '0;
            expect_filter_in = 1'b1;
            rows_done_in     = rows_done_ff + 1'b1;
         end else begin
            col_in = col_next[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_filter_ff <= 1'b1;
         filter_ff        <= pngu_pkg::FILT_NONE;
         col_ff           <= '0;
         hwm_ff           <= '0;
         rows_done_ff     <= '0;
         halted_ff        <= 1'b0;
      end else begin
         expect_filter_ff <= expect_filter_in;
         filter_ff        <= filter_in;
         col_ff           <= col_in;
         hwm_ff           <= hwm_in;
         rows_done_ff     <= rows_done_in;
         halted_ff        <= halted_in;
      end
   end

   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !q_push)
      else $error("beat queued after halt");

endmodule

// ===== hw/rtl/pngu_back.sv =====
`timescale 1ns / 1ps
module pngu_back #(
   parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  pngu_pkg::pngu_entry_type q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_pixel_byte,
   output logic                     rsp_row_end,
   output logic                     rsp_bad_filter
);

   localparam int AddrW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int Hist  = pngu_pkg::HIST_DEPTH;

   logic [7:0] prior_mem [MAX_ROW_BYTES];

   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   pngu_pkg::pngu_entry_type s1_entry_ff;
   logic                     s1_fwd_ff;
   logic [7:0]               s1_fwd_data_ff;
   logic [7:0]               mem_rdata_ff;
   logic [7:0]               left_ff [Hist];
   logic [7:0]               upper_ff [Hist];
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [7:0]               rsp_pixel_ff;
   logic                     rsp_row_end_ff;
   logic                     rsp_bad_ff;

   logic             out_free;
   logic             s1_adv;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [AddrW-1:0] rd_addr;
   logic [7:0]       a;
   logic [7:0]       b;
   logic [7:0]       c;
   logic [8:0]       ab_sum;
   logic [7:0]       pred;
   logic [7:0]       rec;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign q_pop    = q_valid && (!s1_valid_ff || s1_adv);
   assign wr_en    = s1_adv && !s1_entry_ff.bad;
   assign wr_addr  = s1_entry_ff.idx[AddrW-1:0];
   assign rd_addr  = q_head.idx[AddrW-1:0];

   // Pick neighbors and rebuild the byte
   always_comb begin
      if (!s1_entry_ff.up_valid) begin
         b = 8'd0;
      end else if (s1_fwd_ff) begin
         b = s1_fwd_data_ff;
      end else begin
         b = mem_rdata_ff;
      end
      a      = s1_entry_ff.use_left ? left_ff[s1_entry_ff.bpp_sel] : 8'd0;
      c      = s1_entry_ff.use_left ? upper_ff[s1_entry_ff.bpp_sel] : 8'd0;
      ab_sum = {1'b0, a} + {1'b0, b};
      case (s1_entry_ff.filter)
         pngu_pkg::FILT_SUB:   pred = a;
         pngu_pkg::FILT_UP:    pred = b;
         pngu_pkg::FILT_AVG:   pred = ab_sum[8:1];
         pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth(a, b, c);
         default:              pred = 8'd0;
      endcase
      rec = s1_entry_ff.data + pred;
   end

   // Stage occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load read stage; forward a same-column write from the beat ahead
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_entry_ff    <= q_head;
         s1_fwd_ff      <= wr_en && (wr_addr == rd_addr);
         s1_fwd_data_ff <= rec;
      end
   end

   // Prior-row memory
   always_ff @(posedge clock) begin
      if (q_pop) begin
         mem_rdata_ff <= prior_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prior_mem[wr_addr] <= rec;
      end
   end

   // Shift neighbor history on data beats
   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_ff[0]  <= rec;
         upper_ff[0] <= b;
         for (int k = 1; k < Hist; k++) begin
            left_ff[k]  <= left_ff[k-1];
            upper_ff[k] <= upper_ff[k-1];
         end
      end
   end

   // Load output register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pixel_ff   <= s1_entry_ff.bad ? 8'd0 : rec;
         rsp_row_end_ff <= s1_entry_ff.bad ? 1'b0 : s1_entry_ff.last;
         rsp_bad_ff     <= s1_entry_ff.bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_bad_filter = rsp_bad_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("read stage lost a beat while stalled");

   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (rsp_valid_ff && !rsp_bad_ff))
      else $error("row write without a result");

endmodule

// ===== hw/rtl/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
// A data byte passes through the queue, the read stage and the output reg before rsp_valid rises.
// Throughput: one byte per cycle unless rsp_ready or a full queue stalls; the loop is rebuild-and-shift of the history.
// Filter bytes and bytes past the last row give no result; a bad filter code gives rsp_bad_filter and halts.
// Reset: synchronous; clears control state, registers go to 1. The prior-row memory is
// not swept; a written-columns mark makes unwritten columns read as zero.
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF,
   parameter int MAX_ROWS        = pngu_pkg::MAX_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_row_end,
   output logic        rsp_bad_filter,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pngu_pkg::pngu_cfg_type   cfg_ff;
   pngu_pkg::pngu_cfg_type   cfg_in;
   pngu_pkg::pngu_entry_type push_entry;
   pngu_pkg::pngu_entry_type head_entry;
   logic                     push;
   logic                     pop;
   logic                     head_valid;
   logic                     q_full;
   logic                     csr_wr;
   logic [1:0]               csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            pngu_pkg::REG_ROW_BYTES:   cfg_in.row_bytes   = csr_pwdata[15:0];
            pngu_pkg::REG_PIXEL_BYTES: cfg_in.pixel_bytes = csr_pwdata[3:0];
            pngu_pkg::REG_ROW_COUNT:   cfg_in.row_count   = csr_pwdata[12:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_bytes   <= 16'd1;
         cfg_ff.pixel_bytes <= 4'd1;
         cfg_ff.row_count   <= 13'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register readback
   always_comb begin
      case (csr_idx)
         pngu_pkg::REG_ROW_BYTES:   csr_prdata = 32'(cfg_ff.row_bytes);
         pngu_pkg::REG_PIXEL_BYTES: csr_prdata = 32'(cfg_ff.pixel_bytes);
         pngu_pkg::REG_ROW_COUNT:   csr_prdata = 32'(cfg_ff.row_count);
         default:                   csr_prdata = 32'd0;
      endcase
   end

   pngu_front #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
      .MAX_ROWS        (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .q_push      (push),
      .q_entry     (push_entry)
   );

   pngu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (q_full)
   );

   pngu_back #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (head_valid),
      .q_head         (head_entry),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_bad_filter (rsp_bad_filter)
   );

endmodule
